@@ hdl/srw_pkg.sv @@
// Shared types and constants for the serial register write block.
// Holds the item structs, frame geometry and chip-select codes.
// Depends on nothing; every other file imports it.
package srw_pkg;

   // frame geometry
   localparam int FRAME_BITS = 24;
   localparam int FIELD_BITS = 12;
   localparam int CNT_W      = $clog2(FRAME_BITS);
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // panel window: address[15:7] selects 0xF00..0xF7F
   localparam logic [8:0] PANEL_WINDOW  = 9'h01E;
   // framed address bits 11..5 of a remapped panel address (0xF00)
   localparam logic [6:0] PANEL_REMAP_HI = 7'h78;

   // sub-window codes, address[6:5] inside the panel window
   localparam logic [1:0] WIN_ALL   = 2'd0;
   localparam logic [1:0] WIN_RED   = 2'd1;
   localparam logic [1:0] WIN_GREEN = 2'd2;
   localparam logic [1:0] WIN_BLUE  = 2'd3;

   // chip-select masks
   localparam logic [3:0] SEL_CTRL  = 4'h8;
   localparam logic [3:0] SEL_RED   = 4'h4;
   localparam logic [3:0] SEL_GREEN = 4'h2;
   localparam logic [3:0] SEL_BLUE  = 4'h1;
   localparam logic [3:0] SEL_ALL   = 4'h7;

   typedef struct packed {
      logic [15:0] reg_address;
      logic [11:0] reg_value;
   } req_item_type;

   typedef struct packed {
      logic [3:0] select_mask;
      logic       serial_bit;
      logic       frame_end;
   } rsp_item_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [3:0]            select_mask;
      logic [FRAME_BITS-1:0] frame;
   } frame_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/srw_front.sv @@
// Front end: accepts register writes, decodes chip select, builds the frame.
// Pushes classified items into the queue. Depends on srw_pkg.
module srw_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  srw_pkg::req_item_type    req_item,
   output logic                     busy,
   input  srw_pkg::queue_status_type q_status,
   output logic                     push,
   output srw_pkg::frame_item_type  push_item
);
   import srw_pkg::*;

   logic                  front_valid_ff, front_valid_in;
   frame_item_type        front_item_ff, front_item_in;
   frame_item_type        decoded;
   logic                  take;
   logic                  move;
   logic                  in_panel;
   logic [FIELD_BITS-1:0] framed_addr;

   // decode chip select and remap panel addresses
   always_comb begin
      in_panel = (req_item.reg_address[15:7] == PANEL_WINDOW);
      decoded.select_mask = SEL_CTRL;
      if (in_panel) begin
         unique case (req_item.reg_address[6:5])
            WIN_ALL:   decoded.select_mask = SEL_ALL;
            WIN_RED:   decoded.select_mask = SEL_RED;
            WIN_GREEN: decoded.select_mask = SEL_GREEN;
            WIN_BLUE:  decoded.select_mask = SEL_BLUE;
            default:   decoded.select_mask = SEL_CTRL;
         endcase
      end
      framed_addr = in_panel ? {PANEL_REMAP_HI, req_item.reg_address[4:0]}
                             : req_item.reg_address[11:0];
      decoded.frame = {framed_addr, req_item.reg_value};
   end

   // hold one item; advance it into the queue when there is room
   assign move = front_valid_ff && !q_status.full;
   assign busy = front_valid_ff && q_status.full;
   assign take = start && !busy;

   assign push      = move;
   assign push_item = front_item_ff;

   always_comb begin
      front_valid_in = take || (front_valid_ff && !move);
      front_item_in  = take ? decoded : front_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_item_ff <= front_item_in;
   end

endmodule

@@ hdl/srw_queue.sv @@
// Short item queue between the front end and the serializer.
// Ring buffer with wrap-around pointers and a fill count. Depends on srw_pkg.
module srw_queue #(
   parameter int QUEUE_DEPTH = srw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  srw_pkg::frame_item_type   push_item,
   input  logic                      pop,
   output srw_pkg::frame_item_type   pop_item,
   output srw_pkg::queue_status_type q_status
);
   import srw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   frame_item_type     mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  fill_ff, fill_in;

   assign q_status.full  = (fill_ff == CNT_QW'(QUEUE_DEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign pop_item = mem[rd_ptr_ff];

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/srw_serializer.sv @@
// Back end: shifts each queued frame out one bit per clock, MSB first.
// Drives the result strobe and item directly from its registers. Depends on srw_pkg.
module srw_serializer (
   input  logic                      clock,
   input  logic                      reset,
   input  srw_pkg::queue_status_type q_status,
   input  srw_pkg::frame_item_type   pop_item,
   output logic                      pop,
   output logic                      rsp_strobe,
   output srw_pkg::rsp_item_type     rsp_item
);
   import srw_pkg::*;

   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

   logic                  active_ff, active_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [3:0]            sel_ff, sel_in;
   logic                  last;

   assign last = active_ff && (cnt_ff == LAST_BIT);
   // load the next frame when idle or on the final bit
   assign pop  = !q_status.empty && (!active_ff || last);

   always_comb begin
      active_in = pop || (active_ff && !last);
      cnt_in    = cnt_ff + 1'b1;
      shift_in  = {shift_ff[FRAME_BITS-2:0], 1'b0};
      sel_in    = sel_ff;
      if (pop) begin
         cnt_in   = '0;
         shift_in = pop_item.frame;
         sel_in   = pop_item.select_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
      shift_ff <= shift_in;
      sel_ff   <= sel_in;
   end

   // present the current bit
   assign rsp_strobe           = active_ff;
   assign rsp_item.select_mask = sel_ff;
   assign rsp_item.serial_bit  = shift_ff[FRAME_BITS-1];
   assign rsp_item.frame_end   = last;

endmodule

@@ hdl/serial_register_write_with_cs_decode_core.sv @@
// Top level of the serial register write block with chip-select decode.
// Ties front end, item queue and serializer together. Depends on srw_pkg
// and the srw_front, srw_queue and srw_serializer modules.
//
// Each accepted write (start high while busy is low) yields a 24-bit frame,
// address bits 11..0 then value bits 11..0, one bit per clock on rsp_item
// with rsp_strobe high; every bit carries the frame's chip-select mask and
// the 24th bit carries frame_end. Frames follow one another without gaps
// while the queue holds the next one, as the serializer shifts one bit
// per clock. From an idle block a taken write passes the front-end register
// and the queue before the serializer loads it. The front end holds one
// item and the queue holds QUEUE_DEPTH more, so several writes can be
// taken while a frame is still going out; busy rises only when both are
// full. The receiver cannot stall: each bit is valid for exactly one clock.
module serial_register_write_with_cs_decode_core #(
   parameter int QUEUE_DEPTH = srw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  srw_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output srw_pkg::rsp_item_type rsp_item
);
   import srw_pkg::*;

   queue_status_type q_status;
   frame_item_type   push_item;
   frame_item_type   pop_item;
   logic             push;
   logic             pop;

   srw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   srw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   srw_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // a frame, once started, runs without gaps and keeps its mask
   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.frame_end |=> rsp_strobe && $stable(rsp_item.select_mask))
      else $error("frame interrupted or select mask changed mid-frame");

   // the select mask is a single line or all three panels
   a_mask_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($onehot(rsp_item.select_mask) || rsp_item.select_mask == SEL_ALL))
      else $error("illegal select mask");

   // busy only when the queue is full
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> q_status.full && !q_status.empty)
      else $error("busy without a full queue");

   // nothing leaves the queue without a frame starting next cycle
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_strobe)
      else $error("popped item did not start a frame");

endmodule
